FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the clocked concurrent assertions of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define SVRI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SVRI_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/svri_pkg.sv
// ----------------------------------------------------------------------------
// svri_pkg
// Types and constants of the serial volume register interface.
// ----------------------------------------------------------------------------
package svri_pkg;

    // Field widths.
    localparam int unsigned ByteW  = 8;
    localparam int unsigned AttenW = 6;
    localparam int unsigned CountW = 4;
    localparam int unsigned ChanW  = 2;

    // Bit positions within the written byte.
    localparam int unsigned BitStrobe  = 0;
    localparam int unsigned BitData    = 1;
    localparam int unsigned BitClock   = 2;
    localparam int unsigned BitLowpass = 3;
    localparam int unsigned BitMute    = 4;

    // Serial link limits.
    localparam logic [AttenW-1:0] MaxAtten   = AttenW'(43);
    localparam logic [CountW-1:0] CommitBits = CountW'(11);
    localparam logic [CountW-1:0] CountCap   = CountW'(12);
    localparam logic [CountW-1:0] ChanFirst  = CountW'(3);
    localparam logic [CountW-1:0] VolFirst   = CountW'(5);

    // Strobe status codes.
    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_COMMIT = 2'd1,
        ST_CLAMP  = 2'd2,
        ST_REJECT = 2'd3
    } t_status;

    // One result word as it travels from the link logic to the output stage.
    typedef struct packed {
        logic              mute;
        logic              lowpass;
        logic [AttenW-1:0] left;
        logic [AttenW-1:0] right;
        t_status           status;
    } t_result;

endpackage

FILE: rtl/svri_in_if.sv
// ----------------------------------------------------------------------------
// svri_in_if
// Input channel: one written output byte per word.
// ----------------------------------------------------------------------------
interface svri_in_if import svri_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [ByteW-1:0] gpo_byte;

    modport source (output valid, output gpo_byte, input ready);
    modport sink   (input valid, input gpo_byte, output ready);

endinterface

FILE: rtl/svri_out_if.sv
// ----------------------------------------------------------------------------
// svri_out_if
// Output channel: flags, committed attenuations and strobe status per word.
// ----------------------------------------------------------------------------
interface svri_out_if import svri_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              mute_flag;
    logic              lowpass_flag;
    logic [AttenW-1:0] left_attenuation;
    logic [AttenW-1:0] right_attenuation;
    logic [1:0]        strobe_status;

    modport source (
        output valid, output mute_flag, output lowpass_flag,
        output left_attenuation, output right_attenuation, output strobe_status,
        input  ready
    );
    modport sink (
        input  valid, input mute_flag, input lowpass_flag,
        input  left_attenuation, input right_attenuation, input strobe_status,
        output ready
    );

endinterface

FILE: rtl/svri_link.sv
// ----------------------------------------------------------------------------
// svri_link
// Serial link state: edge detection, shift registers, commit and levels.
// ----------------------------------------------------------------------------
module svri_link import svri_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [ByteW-1:0] i_byte,
    output t_result          o_result
);

    logic              r_prev_clock;
    logic [CountW-1:0] r_count;
    logic [ChanW-1:0]  r_chan;
    logic [AttenW-1:0] r_vol;
    logic [AttenW-1:0] r_left;
    logic [AttenW-1:0] r_right;

    logic              n_count_clr;
    logic [CountW-1:0] n_count;
    logic [ChanW-1:0]  n_chan;
    logic [AttenW-1:0] n_vol;
    logic [AttenW-1:0] n_left;
    logic [AttenW-1:0] n_right;
    logic [AttenW-1:0] vol_clamped;
    t_status           status;

    logic strobe;
    logic clk_bit;
    logic data_bit;

    assign strobe   = i_byte[BitStrobe];
    assign clk_bit  = i_byte[BitClock];
    assign data_bit = i_byte[BitData];

    // Attenuation limited to the largest step.
    assign vol_clamped = (r_vol > MaxAtten) ? MaxAtten : r_vol;

    // Next state of the link for this word.
    always_comb begin
        n_count_clr = 1'b0;
        n_count     = r_count;
        n_chan      = r_chan;
        n_vol       = r_vol;
        n_left      = r_left;
        n_right     = r_right;
        status      = ST_NONE;
        priority if (strobe) begin
            if (r_count != CommitBits) begin
                status = ST_REJECT;
            end else begin
                status = (r_vol > MaxAtten) ? ST_CLAMP : ST_COMMIT;
                n_vol  = vol_clamped;
                if (r_chan[0]) begin
                    n_left = vol_clamped;
                end
                if (r_chan[1]) begin
                    n_right = vol_clamped;
                end
            end
        end else if (clk_bit && !r_prev_clock) begin
            // Rising edge: place the data bit by its position in the word.
            if (r_count >= ChanFirst && r_count < VolFirst) begin
                n_chan = {r_chan[ChanW-2:0], data_bit};
            end else if (r_count >= VolFirst && r_count < CommitBits) begin
                n_vol = {r_vol[AttenW-2:0], data_bit};
            end
            if (r_count < CountCap) begin
                n_count = r_count + CountW'(1);
            end
        end else if (clk_bit == r_prev_clock) begin
            // Clock level held: the transfer is abandoned.
            n_count_clr = 1'b1;
        end else begin
            // Falling edge: only the clock level is recorded.
            n_count_clr = 1'b0;
        end
    end

    // State registers advance only when a word is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_clock <= 1'b0;
            r_count      <= '0;
            r_chan       <= '0;
            r_vol        <= '0;
            r_left       <= '0;
            r_right      <= '0;
        end else if (i_en) begin
            r_prev_clock <= clk_bit;
            r_left       <= n_left;
            r_right      <= n_right;
            if (n_count_clr) begin
                r_count <= '0;
                r_chan  <= '0;
                r_vol   <= '0;
            end else begin
                r_count <= n_count;
                r_chan  <= n_chan;
                r_vol   <= n_vol;
            end
        end
    end

    // Result of this word, levels as they stand after the update.
    assign o_result = '{
        mute:    i_byte[BitMute],
        lowpass: i_byte[BitLowpass],
        left:    n_left,
        right:   n_right,
        status:  status
    };

endmodule

FILE: rtl/svri_out_stage.sv
// ----------------------------------------------------------------------------
// svri_out_stage
// Output register holding one result word until the sink takes it.
// ----------------------------------------------------------------------------
module svri_out_stage import svri_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_can_load,
    svri_out_if.source o_out
);

    logic    r_valid;
    t_result r_result;

    // A new word may enter when the register is empty or being drained.
    assign o_can_load = !r_valid || o_out.ready;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid             = r_valid;
    assign o_out.mute_flag         = r_result.mute;
    assign o_out.lowpass_flag      = r_result.lowpass;
    assign o_out.left_attenuation  = r_result.left;
    assign o_out.right_attenuation = r_result.right;
    assign o_out.strobe_status     = r_result.status;

endmodule

FILE: rtl/serial_volume_register_interface_top.sv
// The block takes one written output byte per word and returns one result word
// for it, at a sustained rate of one word per clock cycle while the sink keeps
// taking results. A word is held first in the input register, then the logic
// that updates the serial link state loads its result into the output register,
// from which it is offered. The input side keeps accepting while a result waits,
// and stalls only when both the input register and the output register hold
// words the sink has not taken.
// ----------------------------------------------------------------------------
// serial_volume_register_interface_top
// Serial volume register interface: mute and low-pass flags, an 11-bit
// serial link with clamped left and right attenuation commit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module serial_volume_register_interface_top import svri_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    svri_in_if.sink    i_in,
    svri_out_if.source o_out
);

    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    logic             can_load;
    logic             advance;
    t_result          result;

    logic             in_accept;
    logic             atten_ok;
    logic             stalled;
    logic             pipe_empty;

    // The registered word moves on when the output stage can take it.
    assign advance    = r_in_valid && can_load;
    assign i_in.ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.gpo_byte;
        end
    end

    svri_link u_link (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_byte   (r_in_byte),
        .o_result (result)
    );

    svri_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (result),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

    // Conditions watched by the checks.
    assign in_accept  = i_in.valid && i_in.ready;
    assign atten_ok   = (o_out.left_attenuation <= MaxAtten) &&
                        (o_out.right_attenuation <= MaxAtten);
    assign stalled    = r_in_valid && !advance;
    assign pipe_empty = !o_out.valid && !r_in_valid;

    // Checks.
    `SVRI_ASSERT(a_atten_range, i_clk, i_rst_n, o_out.valid |-> atten_ok, "attenuation above limit")
    `SVRI_ASSERT(a_in_capture, i_clk, i_rst_n, in_accept |=> r_in_valid, "accepted word not held")
    `SVRI_ASSERT(a_no_drop, i_clk, i_rst_n, stalled |=> r_in_valid, "stalled word lost")
    `SVRI_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> pipe_empty, "not empty after reset")

endmodule
